// ----- sv/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte search core
// Transaction payloads, cell control, register indexes and count limits.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 3;

    // Fixed register file geometry
    localparam int unsigned LEN_W       = 6;
    localparam int unsigned PAT_BYTES   = 32;
    localparam int unsigned PAT_WORDS   = 4;
    localparam int unsigned COUNT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_THIRD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WILDCARD_MASK  = 3'd5;

    // Input transaction
    typedef struct packed {
        logic [7:0] scan_byte;
        logic       end_of_image;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] match_offset;
    } out_item_t;

    // Control that every window cell sees
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- sv/wbps_cell.sv -----
// ----------------------------------------------------------------------------
// wbps_cell: one byte cell of the search window
// Holds one past image byte, hands it to the next cell on each shift and
// compares it with the pattern byte aligned to its position.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire wbps_pkg::cell_ctl_t ctl,
    input  wire logic [7:0]         byte_in,
    input  wire logic [7:0]         pat_byte,
    input  wire logic               care,
    output logic [7:0]              byte_out,
    output logic                    hit
);

    logic [7:0] win_byte_reg;
    logic [7:0] win_byte_next;

    // Clear at end of image, take the neighbor's byte on shift, else hold
    always_comb begin
        win_byte_next = win_byte_reg;
        if (ctl.clear) begin
            win_byte_next = 8'h00;
        end else if (ctl.shift) begin
            win_byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_byte_reg <= 8'h00;
        end else begin
            win_byte_reg <= win_byte_next;
        end
    end

    // Masked compare against the aligned pattern byte
    assign hit      = !care || (win_byte_reg == pat_byte);
    assign byte_out = win_byte_reg;

endmodule

`default_nettype wire

// ----- sv/wbps_out_buf.sv -----
// ----------------------------------------------------------------------------
// wbps_out_buf: two-entry result buffer
// Parts the scan side from the result side so a new byte is taken while a
// finished result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_out_buf (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire wbps_pkg::out_item_t push_data,
    output logic                     has_space,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wbps_pkg::out_item_t      m_data
);

    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    wbps_pkg::out_item_t head_reg;
    wbps_pkg::out_item_t head_next;
    wbps_pkg::out_item_t spare_reg;
    wbps_pkg::out_item_t spare_next;
    logic                pop;

    assign pop = m_valid && m_ready;

    // Update occupancy and move entries toward the head
    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
        if (pop && (count_reg == 2'd2)) begin
            head_next = spare_reg;
        end else if (push && ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop))) begin
            head_next = push_data;
        end
        if (push && (count_reg == 2'd1) && !pop) begin
            spare_next = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign has_space = (count_reg != 2'd2);
    assign m_valid   = (count_reg != 2'd0);
    assign m_data    = head_reg;

    // Occupancy never passes two entries
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    // No result arrives while both entries are taken
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != 2'd2))
        else $error("result pushed into full buffer");

    // A waiting head result holds until taken
    a_head_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("waiting result changed");

endmodule

`default_nettype wire

// ----- sv/wildcard_byte_pattern_search_core.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core: wildcard byte signature search
// Scans an image one byte per transaction and reports the first offset at
// which the configured masked pattern matches, or a miss at image end.
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  ---------+--------------------------------+-----------------------------------
//  s_       | s_valid s_ready s_data         | scan_byte, end_of_image
//  m_       | m_valid m_ready m_data         | found, match_offset
//  cfg_wr_  | cfg_wr_en cfg_wr_index/data    | register write, no handshake
//
//  One byte is taken every cycle while s_ready is high; window cells shift and
//  all compares resolve in that cycle; a registered result buffer drives m_valid.
//  Reset is synchronous on aresetn low and clears registers, window and count.
//  Results sit in a two-entry buffer; s_ready drops only while both entries
//  wait on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_search_core #(
    parameter int unsigned PATTERN_MAX = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire wbps_pkg::in_item_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output wbps_pkg::out_item_t                      m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int unsigned PB = wbps_pkg::PAT_BYTES;
    localparam logic [wbps_pkg::LEN_W-1:0] LEN_LIMIT = wbps_pkg::LEN_W'(PATTERN_MAX);
    localparam logic [wbps_pkg::LEN_W-1:0] LEN_FULL  = wbps_pkg::LEN_W'(PB);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [wbps_pkg::LEN_W-1:0]      cfg_len_reg;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_word_reg [wbps_pkg::PAT_WORDS];
    logic [PB-1:0]                   cfg_wild_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_len_reg  <= '0;
            cfg_wild_reg <= '0;
            for (int w = 0; w < wbps_pkg::PAT_WORDS; w++) begin
                cfg_word_reg[w] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                wbps_pkg::CFG_PATTERN_LENGTH: begin
                    cfg_len_reg <= cfg_wr_data[wbps_pkg::LEN_W-1:0];
                end
                wbps_pkg::CFG_PATTERN_LOW:    cfg_word_reg[0] <= cfg_wr_data;
                wbps_pkg::CFG_PATTERN_SECOND: cfg_word_reg[1] <= cfg_wr_data;
                wbps_pkg::CFG_PATTERN_THIRD:  cfg_word_reg[2] <= cfg_wr_data;
                wbps_pkg::CFG_PATTERN_HIGH:   cfg_word_reg[3] <= cfg_wr_data;
                wbps_pkg::CFG_WILDCARD_MASK: begin
                    cfg_wild_reg <= cfg_wr_data[PB-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Align pattern to window positions: position d (d bytes back from the
    // current byte) checks pattern byte len-1-d. Reverse the pattern, then
    // shift it down by 32-len bytes.
    // ------------------------------------------------------------------
    logic [PB*8-1:0]            pat_flat;
    logic [PB*8-1:0]            pat_rev;
    logic [PB-1:0]              wild_rev;
    logic [wbps_pkg::LEN_W-1:0] align_shift;
    logic [PB*8-1:0]            pat_aligned;
    logic [PB-1:0]              care_aligned;
    logic [PB-1:0]              len_mask;

    assign pat_flat = {cfg_word_reg[3], cfg_word_reg[2], cfg_word_reg[1], cfg_word_reg[0]};

    for (genvar j = 0; j < PB; j++) begin : g_rev
        assign pat_rev[(PB-1-j)*8 +: 8] = pat_flat[j*8 +: 8];
        assign wild_rev[PB-1-j]         = cfg_wild_reg[j];
    end

    assign align_shift  = LEN_FULL - cfg_len_reg;
    assign pat_aligned  = pat_rev >> {align_shift, 3'b000};
    assign len_mask     = ~({PB{1'b1}} << cfg_len_reg);
    assign care_aligned = ~(wild_rev >> align_shift) & len_mask;

    // ------------------------------------------------------------------
    // Scan control
    // ------------------------------------------------------------------
    logic                              s_fire;
    logic                              buf_space;
    wbps_pkg::cell_ctl_t               cell_ctl;
    logic [wbps_pkg::COUNT_W-1:0]      bytes_seen_reg;
    logic [wbps_pkg::COUNT_W-1:0]      bytes_seen_next;
    logic                              reported_reg;
    logic                              reported_next;

    assign s_ready        = buf_space;
    assign s_fire         = s_valid && s_ready;
    assign cell_ctl.shift = s_fire && !s_data.end_of_image;
    assign cell_ctl.clear = s_fire && s_data.end_of_image;

    // ------------------------------------------------------------------
    // Window chain: position 0 is the incoming byte, cell k holds the byte
    // k+1 positions back
    // ------------------------------------------------------------------
    logic [7:0]             chain_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit;

    assign chain_byte[0] = s_data.scan_byte;
    assign hit[0]        = !care_aligned[0] || (s_data.scan_byte == pat_aligned[7:0]);

    for (genvar k = 0; k < PATTERN_MAX - 1; k++) begin : g_cell
        wbps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (cell_ctl),
            .byte_in  (chain_byte[k]),
            .pat_byte (pat_aligned[(k+1)*8 +: 8]),
            .care     (care_aligned[k+1]),
            .byte_out (chain_byte[k+1]),
            .hit      (hit[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Match decision and result
    // ------------------------------------------------------------------
    logic                         len_ok;
    logic                         count_ok;
    logic                         match;
    logic                         emit;
    wbps_pkg::out_item_t          result;
    logic [wbps_pkg::COUNT_W-1:0] len_ext;

    assign len_ext  = wbps_pkg::COUNT_W'(cfg_len_reg);
    assign len_ok   = (cfg_len_reg != '0) && (cfg_len_reg <= LEN_LIMIT);
    assign count_ok = (bytes_seen_reg >= (len_ext - 32'd1));
    assign match    = !reported_reg && len_ok && count_ok && (&hit);
    assign emit     = s_fire && (match || (s_data.end_of_image && !reported_reg));

    always_comb begin
        result.found        = match;
        result.match_offset = '0;
        if (match) begin
            result.match_offset = bytes_seen_reg + 32'd1 - len_ext;
        end
    end

    // Advance the count and report flag, drop both at end of image
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        if (cell_ctl.clear) begin
            bytes_seen_next = '0;
            reported_next   = 1'b0;
        end else if (cell_ctl.shift) begin
            if (bytes_seen_reg != wbps_pkg::COUNT_MAX) begin
                bytes_seen_next = bytes_seen_reg + 32'd1;
            end
            if (match) begin
                reported_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            reported_reg   <= reported_next;
        end
    end

    wbps_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (result),
        .has_space (buf_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // End of image leaves a clean count and report flag
    a_clear_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_image) |=> (bytes_seen_reg == '0 && !reported_reg))
        else $error("state not cleared after end of image");

    // A miss result only comes with the last byte of an image
    a_miss_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !result.found) |-> s_data.end_of_image)
        else $error("miss reported before end of image");

    // No second hit once a match has been reported in this image
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        reported_reg |-> !match)
        else $error("second match in one image");

endmodule

`default_nettype wire
